>>> sv/ect_pkg.sv
package ect_pkg;

    // Default token buffer size
    localparam int MAX_TOKEN_LEN_DEF = 32;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_DIGIT  = 2'd1,
        CLS_OP     = 2'd2,
        CLS_LETTER = 2'd3
    } cls_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ZERO = 2'd1,
        ST_EMIT = 2'd2
    } ect_state_t;

    // One output beat requested from the emit stage
    typedef struct packed {
        logic valid;
        logic zero;      // inserted "0" beat, no memory read
        logic last;      // final character of the token
        logic numeric;
        logic trunc;
        logic expr;
    } issue_t;

    function automatic cls_t class_of(input logic [7:0] c);
        cls_t r;
        r = CLS_NONE;
        if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT) begin
            r = CLS_DIGIT;
        end else if (c == CH_LPAREN || c == CH_RPAREN || c == CH_PLUS ||
                     c == CH_MINUS || c == CH_SLASH || c == CH_STAR ||
                     c == CH_CARET || c == CH_BANG || c == CH_EQ) begin
            r = CLS_OP;
        end else if ((c >= CH_LC_A && c <= CH_LC_Z) ||
                     (c >= CH_UC_A && c <= CH_UC_Z)) begin
            r = CLS_LETTER;
        end
        return r;
    endfunction

endpackage

>>> sv/ect_token_mem.sv
module ect_token_mem import ect_pkg::*; #(
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [2**ADDR_W];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ect_emit.sv
module ect_emit import ect_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  issue_t     iss,
    output logic       iss_ok,
    input  logic [7:0] rd_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_token_end,
    output logic       m_run_end,
    output logic       m_numeric,
    output logic       m_truncated,
    output logic       m_expr_end
);

    // Read-data stage: beat whose memory data is on the read port
    logic   pd_valid_reg, pd_valid_next;
    issue_t pd_tag_reg;
    logic   m_valid_reg, m_valid_next;
    logic   out_load;

    assign out_load = pd_valid_reg && (!m_valid_reg || m_ready);
    assign iss_ok   = !pd_valid_reg || out_load;

    always_comb begin
        pd_valid_next = pd_valid_reg;
        if (iss.valid && iss_ok) begin
            pd_valid_next = 1'b1;
        end else if (out_load) begin
            pd_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pd_valid_reg <= pd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Tags travel alongside the memory read
    always_ff @(posedge aclk) begin
        if (iss.valid && iss_ok) begin
            pd_tag_reg <= iss;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_out_char  <= pd_tag_reg.zero ? CH_ZERO : rd_data;
            m_token_end <= pd_tag_reg.last;
            m_run_end   <= pd_tag_reg.last && !pd_tag_reg.zero;
            m_numeric   <= pd_tag_reg.numeric;
            m_truncated <= pd_tag_reg.trunc;
            m_expr_end  <= pd_tag_reg.expr;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> sv/expression_char_tokenizer.sv
// Expression character tokenizer.
// Input channel (s_valid/s_ready/s_ch) takes one character per beat; a zero
// byte ends the expression, flushes the pending token (a token of other-class
// characters only is dropped) and returns the token state to reset values.
// Output channel (m_valid/m_ready and the m_ fields) delivers one token
// character per beat; m_token_end marks the last character of a token,
// m_run_end the last beat caused by one input beat. A character that does
// not close a token is taken without stopping the input. One that closes a
// buffered token starts its readout: the emit sequencer issues one buffer
// read per cycle on the single memory read port while the emit stage takes
// it, after a "0" beat when one is inserted between "(" and ")". The first
// output beat passes the state register, read-data stage and output register.
// The token buffer is two banks in one memory; the next token fills the other.
// s_ready is low only while a token is being read out. When the receiver
// stalls, the read stage and output register hold their beats and further
// reads stop; once every read of a token has been issued, input beats are
// taken again even while the receiver still stalls.
// Reset (aresetn low, synchronous) clears the control state; the buffer
// memory is not cleared and needs no clearing pass.
module expression_char_tokenizer import ect_pkg::*; #(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_token_end,
    output logic       m_run_end,
    output logic       m_numeric,
    output logic       m_truncated,
    output logic       m_expr_end
);

    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_TOKEN_LEN);
    localparam int ADDR_W = IDX_W + 1;

    ect_state_t       state_reg, state_next;
    cls_t             cur_reg, cur_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             num_reg, num_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       first_reg, first_next;
    logic             at_start_reg, at_start_next;
    logic             prev_open_reg, prev_open_next;
    logic             have_last_reg, have_last_next;
    logic             last_num_reg, last_num_next;
    logic             last_open_reg, last_open_next;
    logic             bank_reg, bank_next;
    logic [LEN_W-1:0] em_len_reg, em_len_next;
    logic [LEN_W-1:0] em_idx_reg, em_idx_next;
    logic             em_bank_reg, em_bank_next;
    logic             em_num_reg, em_num_next;
    logic             em_trunc_reg, em_trunc_next;
    logic             em_expr_reg, em_expr_next;

    issue_t            iss;
    logic              iss_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // Character decode for the beat at the input
    logic             acc, skip, is_sign, is_expr;
    cls_t             cls, cur1, cur_a;
    logic             do_flush, emit, zero_ins, sign_start, ok_num, pos0;
    logic             hl_a, ln_a;
    logic [LEN_W-1:0] len_a;
    logic             num_a, ovf_a;

    assign acc     = s_valid && s_ready;
    assign skip    = (s_ch == CH_SPACE) || (s_ch == CH_COMMA);
    assign is_sign = (s_ch == CH_PLUS) || (s_ch == CH_MINUS);
    assign is_expr = (s_ch == CH_NUL);
    assign cls     = class_of(s_ch);
    assign cur1    = (cur_reg == CLS_NONE) ? cls : cur_reg;

    // Flush decision and post-flush view of the token state
    always_comb begin
        do_flush   = !skip && ((cls != cur1) || (cur1 == CLS_OP));
        emit       = do_flush && (len_reg != '0);
        zero_ins   = emit && have_last_reg && last_open_reg &&
                     (len_reg == LEN_W'(1)) && (first_reg == CH_RPAREN);
        hl_a       = emit ? 1'b1 : have_last_reg;
        ln_a       = emit ? num_reg : last_num_reg;
        len_a      = do_flush ? '0 : len_reg;
        num_a      = do_flush ? 1'b1 : num_reg;
        ovf_a      = do_flush ? 1'b0 : ovf_reg;
        cur_a      = do_flush ? cls : cur1;
        sign_start = !skip && is_sign &&
                     (at_start_reg || (prev_open_reg && !(hl_a && ln_a)));
        pos0       = (len_a == '0) && !ovf_a;
        ok_num     = (cls == CLS_DIGIT) || (pos0 && is_sign);
    end

    // Sequencer and token state update
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        num_next       = num_reg;
        ovf_next       = ovf_reg;
        first_next     = first_reg;
        at_start_next  = at_start_reg;
        prev_open_next = prev_open_reg;
        have_last_next = have_last_reg;
        last_num_next  = last_num_reg;
        last_open_next = last_open_reg;
        bank_next      = bank_reg;
        em_len_next    = em_len_reg;
        em_idx_next    = em_idx_reg;
        em_bank_next   = em_bank_reg;
        em_num_next    = em_num_reg;
        em_trunc_next  = em_trunc_reg;
        em_expr_next   = em_expr_reg;
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = {bank_reg, len_reg[IDX_W-1:0]};
        iss            = '0;
        iss.numeric    = em_num_reg;
        iss.trunc      = em_trunc_reg;
        iss.expr       = em_expr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // Snapshot the closing token for readout
                    if (emit) begin
                        em_len_next    = len_reg;
                        em_idx_next    = '0;
                        em_bank_next   = bank_reg;
                        em_num_next    = num_reg;
                        em_trunc_next  = ovf_reg;
                        em_expr_next   = is_expr;
                        bank_next      = !bank_reg;
                        have_last_next = 1'b1;
                        last_num_next  = num_reg;
                        last_open_next = (len_reg == LEN_W'(1)) &&
                                         (first_reg == CH_LPAREN);
                        state_next     = zero_ins ? ST_ZERO : ST_EMIT;
                    end
                    if (!skip) begin
                        cur_next = cur_a;
                        len_next = len_a;
                        num_next = num_a;
                        ovf_next = ovf_a;
                        if (sign_start) begin
                            // Sign opens a number token
                            len_next   = LEN_W'(1);
                            num_next   = 1'b1;
                            ovf_next   = 1'b0;
                            cur_next   = CLS_DIGIT;
                            first_next = s_ch;
                            wr_en      = 1'b1;
                            wr_addr    = {bank_next, {IDX_W{1'b0}}};
                        end else if (!is_expr) begin
                            if (!ok_num) begin
                                num_next = 1'b0;
                            end
                            if (len_a < LEN_W'(MAX_TOKEN_LEN)) begin
                                wr_en    = 1'b1;
                                wr_addr  = {bank_next, len_a[IDX_W-1:0]};
                                len_next = len_a + LEN_W'(1);
                                if (len_a == '0) begin
                                    first_next = s_ch;
                                end
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    prev_open_next = (cls == CLS_OP) && (s_ch != CH_RPAREN) &&
                                     (s_ch != CH_BANG);
                    at_start_next  = 1'b0;
                    // End of expression returns to the start state
                    if (is_expr) begin
                        cur_next       = CLS_NONE;
                        len_next       = '0;
                        num_next       = 1'b1;
                        ovf_next       = 1'b0;
                        at_start_next  = 1'b1;
                        prev_open_next = 1'b0;
                        have_last_next = 1'b0;
                        last_num_next  = 1'b0;
                        last_open_next = 1'b0;
                    end
                end
            end
            ST_ZERO: begin
                iss.valid   = 1'b1;
                iss.zero    = 1'b1;
                iss.last    = 1'b1;
                iss.numeric = 1'b1;
                iss.trunc   = 1'b0;
                if (iss_ok) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                iss.valid = 1'b1;
                iss.last  = (em_idx_reg == em_len_reg - LEN_W'(1));
                if (iss_ok) begin
                    em_idx_next = em_idx_reg + LEN_W'(1);
                    if (iss.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_en   = iss.valid && iss_ok && !iss.zero;
    assign rd_addr = {em_bank_reg, em_idx_reg[IDX_W-1:0]};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_reg       <= CLS_NONE;
            len_reg       <= '0;
            num_reg       <= 1'b1;
            ovf_reg       <= 1'b0;
            at_start_reg  <= 1'b1;
            prev_open_reg <= 1'b0;
            have_last_reg <= 1'b0;
            last_num_reg  <= 1'b0;
            last_open_reg <= 1'b0;
            bank_reg      <= 1'b0;
            em_len_reg    <= '0;
            em_idx_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            len_reg       <= len_next;
            num_reg       <= num_next;
            ovf_reg       <= ovf_next;
            at_start_reg  <= at_start_next;
            prev_open_reg <= prev_open_next;
            have_last_reg <= have_last_next;
            last_num_reg  <= last_num_next;
            last_open_reg <= last_open_next;
            bank_reg      <= bank_next;
            em_len_reg    <= em_len_next;
            em_idx_reg    <= em_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        first_reg    <= first_next;
        em_bank_reg  <= em_bank_next;
        em_num_reg   <= em_num_next;
        em_trunc_reg <= em_trunc_next;
        em_expr_reg  <= em_expr_next;
    end

    ect_token_mem #(
        .ADDR_W(ADDR_W)
    ) u_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(s_ch),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    ect_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .iss        (iss),
        .iss_ok     (iss_ok),
        .rd_data    (rd_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_token_end(m_token_end),
        .m_run_end  (m_run_end),
        .m_numeric  (m_numeric),
        .m_truncated(m_truncated),
        .m_expr_end (m_expr_end)
    );

    // The last beat of a run always closes a token
    a_run_end_token: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_end |-> m_token_end)
        else $error("run end without token end");

    // Readout never runs past the snapshot length
    a_emit_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> (em_idx_reg < em_len_reg))
        else $error("emit index past token length");

    // Zero byte leaves the tokenizer at the start of a new expression
    a_expr_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && is_expr |=> at_start_reg && (len_reg == '0) &&
                           (cur_reg == CLS_NONE) && !have_last_reg)
        else $error("state not reset after end of expression");

    // Inserted zero is always followed by a buffer read
    a_zero_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ZERO && iss_ok |=> state_reg == ST_EMIT)
        else $error("inserted zero not followed by token readout");

endmodule

>>> sim/ect_token_checker.sv
// Watches both channels of the tokenizer, keeps its own model of the token
// state, and checks every result beat against the oldest predicted beat.
module ect_token_checker import ect_pkg::*; #(
    parameter int TOKEN_CAP = MAX_TOKEN_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_char,
    input  logic       m_token_end,
    input  logic       m_run_end,
    input  logic       m_numeric,
    input  logic       m_truncated,
    input  logic       m_expr_end,
    output int         failures,
    output int         pending,
    output int         beats_seen,
    output int         tokens_seen,
    output int         cut_tokens,
    output int         zeros_added,
    output int         expressions
);

    typedef struct packed {
        logic [7:0] out_char;
        logic       token_end;
        logic       run_end;
        logic       numeric;
        logic       truncated;
        logic       expr_end;
    } token_beat_t;

    // Predicted beats, oldest first
    token_beat_t due_beats[$];

    // Tokenizer state as this model sees it
    logic [7:0] tok_buf [TOKEN_CAP];
    logic [5:0] tok_len;
    cls_t       cur_kind;
    logic       tok_num;
    logic       tok_ovf;
    logic       at_start;
    logic       sign_ok;
    logic       have_last;
    logic       last_num;
    logic       last_lparen;

    // Last beat of the current input beat is held back until run_end is known
    token_beat_t held;
    logic        held_ok;

    token_beat_t got;
    token_beat_t want;
    int          bad;
    int          n_beats;
    int          n_tokens;
    int          n_cut;
    int          n_zeros;
    int          n_exprs;

    function automatic cls_t char_kind(input logic [7:0] c);
        if (c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE))
            return CLS_DIGIT;
        case (c)
            CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS, CH_SLASH,
            CH_STAR, CH_CARET, CH_BANG, CH_EQ: return CLS_OP;
            default: ;
        endcase
        if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z))
            return CLS_LETTER;
        return CLS_NONE;
    endfunction

    task automatic open_token();
        tok_len = '0;
        tok_num = 1'b1;
        tok_ovf = 1'b0;
    endtask

    task automatic restart_expression();
        open_token();
        cur_kind    = CLS_NONE;
        at_start    = 1'b1;
        sign_ok     = 1'b0;
        have_last   = 1'b0;
        last_num    = 1'b0;
        last_lparen = 1'b0;
    endtask

    task automatic stage_beat(input token_beat_t b);
        if (held_ok)
            due_beats.push_back(held);
        held    = b;
        held_ok = 1'b1;
    endtask

    // Emit the buffered token, with a "0" ahead of ")" right after "("
    task automatic emit_token(input logic ends);
        token_beat_t b;
        if (tok_len == 0)
            return;
        if (have_last && last_lparen && tok_len == 1 && tok_buf[0] == CH_RPAREN) begin
            b = '{out_char: CH_ZERO, token_end: 1'b1, run_end: 1'b0, numeric: 1'b1,
                  truncated: 1'b0, expr_end: ends};
            stage_beat(b);
            n_zeros++;
        end
        for (int i = 0; i < tok_len; i++) begin
            b.out_char  = tok_buf[i];
            b.token_end = (i == tok_len - 1);
            b.run_end   = 1'b0;
            b.numeric   = tok_num;
            b.truncated = tok_ovf;
            b.expr_end  = ends;
            stage_beat(b);
        end
        have_last   = 1'b1;
        last_num    = tok_num;
        last_lparen = (tok_len == 1 && tok_buf[0] == CH_LPAREN);
    endtask

    // One accepted character: update the token state, queue its beats
    task automatic tokenize_char(input logic [7:0] c);
        cls_t kind;
        logic ends;
        logic signed_start;
        kind = char_kind(c);
        ends = (c == CH_NUL);
        held_ok = 1'b0;
        if (c != CH_SPACE && c != CH_COMMA) begin
            // other-class characters take the class of what follows
            if (cur_kind == CLS_NONE)
                cur_kind = kind;
            if (kind != cur_kind || cur_kind == CLS_OP) begin
                emit_token(ends);
                open_token();
                cur_kind = kind;
            end
            signed_start = (c == CH_PLUS || c == CH_MINUS) &&
                           (at_start || (sign_ok && !(have_last && last_num)));
            if (signed_start) begin
                open_token();
                tok_buf[0] = c;
                tok_len    = 6'd1;
                cur_kind   = CLS_DIGIT;
            end else if (!ends) begin
                if (!(kind == CLS_DIGIT ||
                      (tok_len == 0 && !tok_ovf && (c == CH_PLUS || c == CH_MINUS))))
                    tok_num = 1'b0;
                if (tok_len < TOKEN_CAP) begin
                    tok_buf[tok_len] = c;
                    tok_len++;
                end else begin
                    tok_ovf = 1'b1;
                end
            end
        end
        sign_ok  = (kind == CLS_OP && c != CH_RPAREN && c != CH_BANG);
        at_start = 1'b0;
        if (held_ok) begin
            held.run_end = 1'b1;
            due_beats.push_back(held);
        end
        if (ends) begin
            restart_expression();
            n_exprs++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_expression();
            due_beats.delete();
            held_ok  = 1'b0;
            bad      = 0;
            n_beats  = 0;
            n_tokens = 0;
            n_cut    = 0;
            n_zeros  = 0;
            n_exprs  = 0;
        end else begin
            // input beat first; its results cannot leave on the same edge
            if (s_valid && s_ready)
                tokenize_char(s_ch);
            if (m_valid && m_ready) begin
                got = '{out_char: m_out_char, token_end: m_token_end, run_end: m_run_end,
                        numeric: m_numeric, truncated: m_truncated, expr_end: m_expr_end};
                n_beats++;
                if (m_token_end) begin
                    n_tokens++;
                    if (m_truncated)
                        n_cut++;
                end
                if (due_beats.size() == 0) begin
                    bad++;
                    if (bad <= 10)
                        $display("%0t: result beat with nothing expected: char %02h", $time,
                                 got.out_char);
                end else begin
                    want = due_beats.pop_front();
                    if (got !== want) begin
                        bad++;
                        if (bad <= 10)
                            $display({"%0t: beat mismatch: expected char %02h end %b run %b ",
                                      "num %b trunc %b expr %b, got char %02h end %b run %b ",
                                      "num %b trunc %b expr %b"}, $time,
                                     want.out_char, want.token_end, want.run_end,
                                     want.numeric, want.truncated, want.expr_end,
                                     got.out_char, got.token_end, got.run_end,
                                     got.numeric, got.truncated, got.expr_end);
                    end
                end
            end
        end
        failures    <= bad;
        pending     <= due_beats.size();
        beats_seen  <= n_beats;
        tokens_seen <= n_tokens;
        cut_tokens  <= n_cut;
        zeros_added <= n_zeros;
        expressions <= n_exprs;
    end

endmodule

>>> sim/expression_char_tokenizer_test.sv
module expression_char_tokenizer_test;
    import ect_pkg::*;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_ch    = 8'h00;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_char;
    logic       m_token_end;
    logic       m_run_end;
    logic       m_numeric;
    logic       m_truncated;
    logic       m_expr_end;

    int   failures;
    int   pending;
    int   beats_seen;
    int   tokens_seen;
    int   cut_tokens;
    int   zeros_added;
    int   expressions;

    // stimulus bookkeeping
    int   sent_chars = 0;
    logic calm       = 1'b0;
    logic long_due   = 1'b1;

    always #5 aclk = ~aclk;

    expression_char_tokenizer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_token_end (m_token_end),
        .m_run_end   (m_run_end),
        .m_numeric   (m_numeric),
        .m_truncated (m_truncated),
        .m_expr_end  (m_expr_end)
    );

    ect_token_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_token_end (m_token_end),
        .m_run_end   (m_run_end),
        .m_numeric   (m_numeric),
        .m_truncated (m_truncated),
        .m_expr_end  (m_expr_end),
        .failures    (failures),
        .pending     (pending),
        .beats_seen  (beats_seen),
        .tokens_seen (tokens_seen),
        .cut_tokens  (cut_tokens),
        .zeros_added (zeros_added),
        .expressions (expressions)
    );

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // One character beat, with an occasional idle gap ahead of it
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 12)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Hold the input off until every predicted beat has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // A random expression built from plausible tokens, some noise, then NUL
    task automatic send_expression();
        int         parts;
        int         len;
        int         kind;
        logic [7:0] c;
        parts = $urandom_range(3, 8);
        for (int p = 0; p < parts; p++) begin
            if ($urandom_range(0, 4) == 0)
                send_char($urandom_range(0, 1) ? CH_SPACE : CH_COMMA);
            len  = $urandom_range(1, 4);
            kind = $urandom_range(0, 9);
            if (long_due) begin
                kind     = 0;
                len      = $urandom_range(33, 38);
                long_due = 1'b0;
            end else if ($urandom_range(0, 59) == 0) begin
                len = $urandom_range(33, 36);
            end
            case (kind)
                0, 1, 2: begin
                    if ($urandom_range(0, 3) == 0)
                        send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    repeat (len) begin
                        c = ($urandom_range(0, 5) == 0) ? CH_DOT :
                            8'(CH_ZERO + $urandom_range(0, 9));
                        send_char(c);
                    end
                end
                3, 4: begin
                    repeat (len) begin
                        c = 8'(($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) +
                               $urandom_range(0, 25));
                        send_char(c);
                    end
                end
                5, 6, 7: begin
                    case ($urandom_range(0, 8))
                        0:       c = CH_LPAREN;
                        1:       c = CH_RPAREN;
                        2:       c = CH_PLUS;
                        3:       c = CH_MINUS;
                        4:       c = CH_SLASH;
                        5:       c = CH_STAR;
                        6:       c = CH_CARET;
                        7:       c = CH_BANG;
                        default: c = CH_EQ;
                    endcase
                    send_char(c);
                end
                8: begin
                    send_char(CH_LPAREN);
                    if ($urandom_range(0, 1))
                        send_char(CH_RPAREN);
                end
                default: send_char(8'($urandom_range(1, 255)));
            endcase
        end
        send_char(CH_NUL);
    endtask

    initial begin
        int   directed_n;
        logic paused_mid;
        paused_mid = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // leading sign, sign after "(", empty parens, skips, other-class prefix
        send_text("-(+a)*()^ 2,!=#b5");
        send_char(CH_NUL);
        // sign with dot, sign after "/", lone sign, no sign after ")", dropped tail
        send_text("+./-)-");
        send_char(8'hFF);
        send_char(CH_NUL);
        wait_drained();

        directed_n = sent_chars;
        while (sent_chars < directed_n + 140) begin
            calm <= (sent_chars - directed_n >= 60) && (sent_chars - directed_n < 110);
            if (!paused_mid && sent_chars - directed_n >= 90) begin
                wait_drained();
                paused_mid = 1'b1;
            end
            send_expression();
        end
        calm <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);

        $display("run covered %0d characters in %0d expressions", sent_chars, expressions);
        $display("checked %0d beats in %0d tokens, %0d truncated, %0d inserted zeros",
                 beats_seen, tokens_seen, cut_tokens, zeros_added);
        if (failures == 0 && pending == 0) begin
            $display("expression_char_tokenizer_test: clean");
        end else begin
            $display("expression_char_tokenizer_test: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("expression_char_tokenizer_test: errors");
        $finish;
    end

endmodule

>>> sim.f
sv/ect_pkg.sv
sv/ect_token_mem.sv
sv/ect_emit.sv
sv/expression_char_tokenizer.sv
sim/ect_token_checker.sv
sim/expression_char_tokenizer_test.sv
